// ----- rtl/sme_pkg.sv -----
// Shared types and constants of the stack machine executor.
package sme_pkg;

    localparam int DATA_W      = 32;
    localparam int OP_W        = 5;
    localparam int SADDR_W     = 5;
    localparam int ADDR_OUT_W  = 12;
    localparam int STATUS_W    = 3;
    localparam int MAX_RESULTS = 32;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 5'd0,
        OP_PUSH   = 5'd1,
        OP_ADD    = 5'd2,
        OP_SUB    = 5'd3,
        OP_MUL    = 5'd4,
        OP_DIV    = 5'd5,
        OP_NEG    = 5'd6,
        OP_AND    = 5'd7,
        OP_OR     = 5'd8,
        OP_NOT    = 5'd9,
        OP_LT     = 5'd10,
        OP_GT     = 5'd11,
        OP_EQ     = 5'd12,
        OP_NE     = 5'd13,
        OP_LE     = 5'd14,
        OP_GE     = 5'd15,
        OP_JUMP   = 5'd16,
        OP_JUMPF  = 5'd17,
        OP_NOP    = 5'd18,
        OP_HALT   = 5'd19,
        OP_LOAD   = 5'd20,
        OP_STORE  = 5'd21
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_HALTED      = 3'd1,
        ST_NOT_STARTED = 3'd2,
        ST_UNDERFLOW   = 3'd3,
        ST_OVERFLOW    = 3'd4,
        ST_DIV_ZERO    = 3'd5,
        ST_BAD_ADDR    = 3'd6
    } stat_t;

    typedef enum logic [2:0] {
        SEQ_IDLE     = 3'd0,
        SEQ_EXEC     = 3'd1,
        SEQ_DIV      = 3'd2,
        SEQ_DUMP_RD  = 3'd3,
        SEQ_DUMP_OUT = 3'd4
    } seq_state_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            div_start;
    } alu_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/sme_stack_ram.sv -----
// Stack storage: one write port, two registered read ports.
module sme_stack_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_idx,
    input  logic [sme_pkg::DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]         rd0_idx,
    input  logic [ADDR_W-1:0]         rd1_idx,
    output logic [sme_pkg::DATA_W-1:0] rd0_data,
    output logic [sme_pkg::DATA_W-1:0] rd1_data
);

    logic [sme_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd0_data <= mem[rd0_idx];
        rd1_data <= mem[rd1_idx];
    end

endmodule

// ----- rtl/sme_alu.sv -----
// Shared arithmetic unit: combinational ops and a bit-serial signed divider.
module sme_alu (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sme_pkg::alu_ctrl_t         ctrl,
    input  logic [sme_pkg::DATA_W-1:0] a,
    input  logic [sme_pkg::DATA_W-1:0] b,
    output logic [sme_pkg::DATA_W-1:0] result,
    output logic [sme_pkg::DATA_W-1:0] quotient,
    output sme_pkg::div_stat_t         div_stat
);

    localparam int DW = sme_pkg::DATA_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [4:0]    step_reg, step_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] mb_reg, mb_next;
    logic          neg_reg, neg_next;
    logic [DW:0]   trial;
    logic          ge;

    always_comb
    begin
        case (ctrl.op)
            sme_pkg::OP_ADD: result = a + b;
            sme_pkg::OP_SUB: result = a - b;
            sme_pkg::OP_MUL: result = a * b;
            sme_pkg::OP_AND: result = DW'(a == DW'(1) && b == DW'(1));
            sme_pkg::OP_OR:  result = DW'(a == DW'(1) || b == DW'(1));
            sme_pkg::OP_LT:  result = DW'($signed(a) < $signed(b));
            sme_pkg::OP_GT:  result = DW'($signed(b) < $signed(a));
            sme_pkg::OP_EQ:  result = DW'(a == b);
            sme_pkg::OP_NE:  result = DW'(a != b);
            sme_pkg::OP_LE:  result = DW'(!($signed(b) < $signed(a)));
            sme_pkg::OP_GE:  result = DW'(!($signed(a) < $signed(b)));
            sme_pkg::OP_NEG: result = DW'(0) - b;
            sme_pkg::OP_NOT: result = DW'(1) - b;
            default:         result = '0;
        endcase
    end

    assign trial = {rem_reg, quo_reg[DW-1]} - {1'b0, mb_reg};
    assign ge    = !trial[DW];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        if (ctrl.div_start)
        begin
            busy_next = 1'b1;
            step_next = '1;
            rem_next  = '0;
            quo_next  = a[DW-1] ? (DW'(0) - a) : a;
            mb_next   = b[DW-1] ? (DW'(0) - b) : b;
            neg_next  = a[DW-1] ^ b[DW-1];
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial[DW-1:0] : {rem_reg[DW-2:0], quo_reg[DW-1]};
            quo_next  = {quo_reg[DW-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        mb_reg   <= mb_next;
        neg_reg  <= neg_next;
    end

    assign quotient      = neg_reg ? (DW'(0) - quo_reg) : quo_reg;
    assign div_stat.busy = busy_reg;
    assign div_stat.done = done_reg;

endmodule

// ----- rtl/stack_machine_executor.sv -----
// Top level of the stack machine executor: sequencer, state and output register.
//
// Input channel s_axis: one decoded instruction per word. The block holds
// s_axis_tready low while an instruction is in flight and while a finished
// result waits in the output register without being taken.
// Output channel m_axis: one result word per instruction; halt with a
// non-empty stack gives one word per stack entry, bottom first, with tuser
// set and tlast on the final word.
// Timing: an instruction is read from stack storage in the cycle it is
// accepted and executed in the next; a new one is accepted only when the
// sequencer is back in idle and the output register is free or being taken.
// Divide runs the shared divider one quotient bit per cycle.
// Halt dump does one storage read per word (DUMP_RD, then DUMP_OUT).
// Reset: the stack is empty, the program counter is zero and the machine
// is not started; stack storage is not cleared.
// When the receiver stalls, the output word holds and no new instruction
// is taken.
module stack_machine_executor #(
    parameter int STACK_DEPTH  = 32,
    parameter int PROGRAM_SIZE = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // operation[4:0], constant_value[36:5], stack_address[41:37],
    // branch_target[53:42], zero fill
    input  logic [sme_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // next_address[11:0], status[14:12], dump_value[46:15], zero fill
    output logic [sme_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // dump_valid
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam int DW     = sme_pkg::DATA_W;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int AX_W   = ADDR_W + sme_pkg::SADDR_W;
    localparam int PC_W   = $clog2(PROGRAM_SIZE);
    localparam int AO_W   = sme_pkg::ADDR_OUT_W;

    function automatic logic [PC_W-1:0] wrap_target(input logic [AO_W-1:0] t);
        logic [AO_W:0] r;
        r = {1'b0, t};
        for (int k = 8; k >= 0; k--)
        begin
            if (int'(r) >= (PROGRAM_SIZE << k))
            begin
                r = r - (AO_W + 1)'(PROGRAM_SIZE << k);
            end
        end
        return PC_W'(r);
    endfunction

    sme_pkg::seq_state_t state_reg, state_next;

    logic [sme_pkg::OP_W-1:0]    op_reg, op_next;
    logic [DW-1:0]               cval_reg, cval_next;
    logic [sme_pkg::SADDR_W-1:0] saddr_reg, saddr_next;
    logic [AO_W-1:0]             tgt_reg, tgt_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [PC_W-1:0]             pc_reg, pc_next;
    logic                        started_reg, started_next;
    logic                        halted_reg, halted_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic [CNT_W-1:0]            dend_reg, dend_next;
    logic                        mvalid_reg, mvalid_next;
    logic [AO_W-1:0]             oaddr_reg, oaddr_next;
    logic [sme_pkg::STATUS_W-1:0] ostat_reg, ostat_next;
    logic [DW-1:0]               oval_reg, oval_next;
    logic                        odv_reg, odv_next;
    logic                        olast_reg, olast_next;

    logic [sme_pkg::OP_W-1:0]    in_op;
    logic [DW-1:0]               in_cval;
    logic [sme_pkg::SADDR_W-1:0] in_saddr;
    logic [AO_W-1:0]             in_tgt;
    logic                        accept;
    logic                        out_free;

    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic [CNT_W-1:0]  idx_p1;
    logic [AX_W-1:0]   in_sa_ext, sa_ext, cnt_ext;
    logic              bad_addr;
    logic [PC_W-1:0]   pc_inc;
    logic [PC_W-1:0]   tgt_wrap;
    logic [PC_W+AO_W-1:0] pc_ext_new;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_widx, ram_r0idx, ram_r1idx;
    logic [DW-1:0]     ram_wdata, rd0, rd1;

    sme_pkg::alu_ctrl_t alu_ctrl;
    sme_pkg::div_stat_t div_stat;
    logic [DW-1:0]      alu_result, quotient;

    sme_pkg::stat_t    ex_status;
    logic              ex_we;
    logic [ADDR_W-1:0] ex_widx;
    logic [DW-1:0]     ex_wdata;
    logic [CNT_W-1:0]  ex_cnt;
    logic [PC_W-1:0]   ex_pc;
    logic              ex_started, ex_halted, ex_div, ex_dump;

    assign in_op    = s_axis_tdata[4:0];
    assign in_cval  = s_axis_tdata[36:5];
    assign in_saddr = s_axis_tdata[41:37];
    assign in_tgt   = s_axis_tdata[53:42];

    assign out_free      = !mvalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == sme_pkg::SEQ_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cnt_m1    = cnt_reg - 1'b1;
    assign cnt_m2    = cnt_reg - 2'd2;
    assign idx_p1    = idx_reg + 1'b1;
    assign in_sa_ext = {{ADDR_W{1'b0}}, in_saddr};
    assign sa_ext    = {{ADDR_W{1'b0}}, saddr_reg};
    assign cnt_ext   = {{(AX_W - CNT_W){1'b0}}, cnt_reg};
    assign bad_addr  = sa_ext >= cnt_ext;
    assign pc_inc    = (pc_reg == PC_W'(PROGRAM_SIZE - 1)) ? '0 : pc_reg + 1'b1;
    assign tgt_wrap  = wrap_target(tgt_reg);

    assign ram_r0idx = (state_reg == sme_pkg::SEQ_DUMP_RD || state_reg == sme_pkg::SEQ_DUMP_OUT)
                       ? idx_reg[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
    assign ram_r1idx = (in_op == sme_pkg::OP_LOAD) ? in_sa_ext[ADDR_W-1:0]
                                                   : cnt_m2[ADDR_W-1:0];

    sme_stack_ram #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk      (clk),
        .wr_en    (ram_we),
        .wr_idx   (ram_widx),
        .wr_data  (ram_wdata),
        .rd0_idx  (ram_r0idx),
        .rd1_idx  (ram_r1idx),
        .rd0_data (rd0),
        .rd1_data (rd1)
    );

    assign alu_ctrl.op        = op_reg;
    assign alu_ctrl.div_start = (state_reg == sme_pkg::SEQ_EXEC) && ex_div;

    sme_alu u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (alu_ctrl),
        .a        (rd1),
        .b        (rd0),
        .result   (alu_result),
        .quotient (quotient),
        .div_stat (div_stat)
    );

    // Decode and execute the held instruction against the stack read.
    always_comb
    begin
        ex_status  = sme_pkg::ST_OK;
        ex_we      = 1'b0;
        ex_widx    = cnt_m1[ADDR_W-1:0];
        ex_wdata   = alu_result;
        ex_cnt     = cnt_reg;
        ex_pc      = pc_reg;
        ex_started = started_reg;
        ex_halted  = halted_reg;
        ex_div     = 1'b0;
        ex_dump    = 1'b0;
        if (op_reg == sme_pkg::OP_START)
        begin
            ex_cnt     = '0;
            ex_started = 1'b1;
            ex_halted  = 1'b0;
            ex_pc      = PC_W'(1);
        end
        else if (!started_reg)
        begin
            ex_status = sme_pkg::ST_NOT_STARTED;
        end
        else if (halted_reg)
        begin
            ex_status = sme_pkg::ST_HALTED;
        end
        else
        begin
            case (op_reg)
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
                sme_pkg::OP_AND, sme_pkg::OP_OR, sme_pkg::OP_LT, sme_pkg::OP_GT,
                sme_pkg::OP_EQ, sme_pkg::OP_NE, sme_pkg::OP_LE, sme_pkg::OP_GE:
                begin
                    if (cnt_reg < CNT_W'(2))
                    begin
                        ex_status = sme_pkg::ST_UNDERFLOW;
                    end
                    else if (op_reg == sme_pkg::OP_DIV && rd0 == '0)
                    begin
                        ex_status = sme_pkg::ST_DIV_ZERO;
                    end
                    else if (op_reg == sme_pkg::OP_DIV)
                    begin
                        ex_div = 1'b1;
                    end
                    else
                    begin
                        ex_we   = 1'b1;
                        ex_widx = cnt_m2[ADDR_W-1:0];
                        ex_cnt  = cnt_m1;
                        ex_pc   = pc_inc;
                    end
                end
                sme_pkg::OP_PUSH, sme_pkg::OP_LOAD:
                begin
                    if (cnt_reg >= CNT_W'(STACK_DEPTH))
                    begin
                        ex_status = sme_pkg::ST_OVERFLOW;
                    end
                    else if (op_reg == sme_pkg::OP_LOAD && bad_addr)
                    begin
                        ex_status = sme_pkg::ST_BAD_ADDR;
                    end
                    else
                    begin
                        ex_we    = 1'b1;
                        ex_widx  = cnt_reg[ADDR_W-1:0];
                        ex_wdata = (op_reg == sme_pkg::OP_LOAD) ? rd1 : cval_reg;
                        ex_cnt   = cnt_reg + 1'b1;
                        ex_pc    = pc_inc;
                    end
                end
                sme_pkg::OP_NEG, sme_pkg::OP_NOT, sme_pkg::OP_JUMPF, sme_pkg::OP_STORE:
                begin
                    if (cnt_reg == '0)
                    begin
                        ex_status = sme_pkg::ST_UNDERFLOW;
                    end
                    else if (op_reg == sme_pkg::OP_JUMPF)
                    begin
                        ex_cnt = cnt_m1;
                        ex_pc  = (rd0 == '0) ? tgt_wrap : pc_inc;
                    end
                    else if (op_reg == sme_pkg::OP_STORE)
                    begin
                        if (bad_addr)
                        begin
                            ex_status = sme_pkg::ST_BAD_ADDR;
                        end
                        else
                        begin
                            ex_we    = 1'b1;
                            ex_widx  = sa_ext[ADDR_W-1:0];
                            ex_wdata = rd0;
                            ex_cnt   = cnt_m1;
                            ex_pc    = pc_inc;
                        end
                    end
                    else
                    begin
                        ex_we = 1'b1;
                        ex_pc = pc_inc;
                    end
                end
                sme_pkg::OP_JUMP:
                begin
                    ex_pc = tgt_wrap;
                end
                sme_pkg::OP_HALT:
                begin
                    ex_halted = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        ex_status = sme_pkg::ST_HALTED;
                    end
                    else
                    begin
                        ex_dump = 1'b1;
                    end
                end
                default:
                begin
                    ex_pc = pc_inc;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sme_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = sme_pkg::SEQ_EXEC;
                end
            end
            sme_pkg::SEQ_EXEC:
            begin
                if (ex_div)
                begin
                    state_next = sme_pkg::SEQ_DIV;
                end
                else if (ex_dump)
                begin
                    state_next = sme_pkg::SEQ_DUMP_RD;
                end
                else
                begin
                    state_next = sme_pkg::SEQ_IDLE;
                end
            end
            sme_pkg::SEQ_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = sme_pkg::SEQ_IDLE;
                end
            end
            sme_pkg::SEQ_DUMP_RD:
            begin
                state_next = sme_pkg::SEQ_DUMP_OUT;
            end
            sme_pkg::SEQ_DUMP_OUT:
            begin
                if (out_free)
                begin
                    state_next = (idx_p1 == dend_reg) ? sme_pkg::SEQ_IDLE
                                                      : sme_pkg::SEQ_DUMP_RD;
                end
            end
            default:
            begin
                state_next = sme_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next      = op_reg;
        cval_next    = cval_reg;
        saddr_next   = saddr_reg;
        tgt_next     = tgt_reg;
        cnt_next     = cnt_reg;
        pc_next      = pc_reg;
        started_next = started_reg;
        halted_next  = halted_reg;
        idx_next     = idx_reg;
        dend_next    = dend_reg;
        mvalid_next  = mvalid_reg && !m_axis_tready;
        oaddr_next   = oaddr_reg;
        ostat_next   = ostat_reg;
        oval_next    = oval_reg;
        odv_next     = odv_reg;
        olast_next   = olast_reg;
        ram_we       = 1'b0;
        ram_widx     = ex_widx;
        ram_wdata    = ex_wdata;
        pc_ext_new   = {{AO_W{1'b0}}, ex_pc};
        case (state_reg)
            sme_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    op_next    = in_op;
                    cval_next  = in_cval;
                    saddr_next = in_saddr;
                    tgt_next   = in_tgt;
                end
            end
            sme_pkg::SEQ_EXEC:
            begin
                ram_we       = ex_we;
                cnt_next     = ex_cnt;
                pc_next      = ex_pc;
                started_next = ex_started;
                halted_next  = ex_halted;
                if (ex_dump)
                begin
                    idx_next  = '0;
                    dend_next = (int'(cnt_reg) > sme_pkg::MAX_RESULTS)
                                ? CNT_W'(sme_pkg::MAX_RESULTS) : cnt_reg;
                end
                else if (!ex_div)
                begin
                    mvalid_next = 1'b1;
                    oaddr_next  = pc_ext_new[AO_W-1:0];
                    ostat_next  = ex_status;
                    oval_next   = '0;
                    odv_next    = 1'b0;
                    olast_next  = 1'b1;
                end
            end
            sme_pkg::SEQ_DIV:
            begin
                if (div_stat.done)
                begin
                    pc_ext_new  = {{AO_W{1'b0}}, pc_inc};
                    ram_we      = 1'b1;
                    ram_widx    = cnt_m2[ADDR_W-1:0];
                    ram_wdata   = quotient;
                    cnt_next    = cnt_m1;
                    pc_next     = pc_inc;
                    mvalid_next = 1'b1;
                    oaddr_next  = pc_ext_new[AO_W-1:0];
                    ostat_next  = sme_pkg::ST_OK;
                    oval_next   = '0;
                    odv_next    = 1'b0;
                    olast_next  = 1'b1;
                end
            end
            sme_pkg::SEQ_DUMP_OUT:
            begin
                if (out_free)
                begin
                    pc_ext_new  = {{AO_W{1'b0}}, pc_reg};
                    mvalid_next = 1'b1;
                    oaddr_next  = pc_ext_new[AO_W-1:0];
                    ostat_next  = sme_pkg::ST_HALTED;
                    oval_next   = rd0;
                    odv_next    = 1'b1;
                    olast_next  = (idx_p1 == dend_reg);
                    idx_next    = idx_p1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sme_pkg::SEQ_IDLE;
            cnt_reg     <= '0;
            pc_reg      <= '0;
            started_reg <= 1'b0;
            halted_reg  <= 1'b0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pc_reg      <= pc_next;
            started_reg <= started_next;
            halted_reg  <= halted_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        cval_reg  <= cval_next;
        saddr_reg <= saddr_next;
        tgt_reg   <= tgt_next;
        idx_reg   <= idx_next;
        dend_reg  <= dend_next;
        oaddr_reg <= oaddr_next;
        ostat_reg <= ostat_next;
        oval_reg  <= oval_next;
        odv_reg   <= odv_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {1'b0, oval_reg, ostat_reg, oaddr_reg};
    assign m_axis_tuser  = odv_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

// ----- rtl/sme_checker.sv -----
// Port-level checks of the stack machine executor, bound to the top level.
module sme_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sme_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);

    // hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tready)
        else $error("input taken while output stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
        else $error("block not busy after accepting a word");

    a_dump_halted: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[14:12] == sme_pkg::ST_HALTED)
        else $error("dump word without halted status");

endmodule

bind stack_machine_executor sme_checker u_sme_checker (.*);
